### design/qecs_pkg.sv
// ----------------------------------------------------------------------------
// qecs_pkg: shared types and constants for the quadrature counter
// Transition table, opcodes, register indexes, port widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package qecs_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned CPR_W           = 16;
    localparam int unsigned MS_W            = 32;
    localparam int unsigned OUT_W           = 32;
    localparam int unsigned LOAD_W          = 32;
    localparam int unsigned RPM_SCALE_W     = 24;
    // 60000 ms per minute, times 256 for eight fraction bits
    localparam logic [RPM_SCALE_W-1:0] RPM_SCALE_Q8 = 24'd15360000;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 96;

    typedef enum logic [1:0] {
        OP_PINS   = 2'd0,
        OP_SPEED  = 2'd1,
        OP_RESET  = 2'd2,
        OP_LOAD   = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_DIR_NEG = 1'b0,
        CFG_CPR     = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_HOLD = 2'd0,
        ST_FWD  = 2'd1,
        ST_REV  = 2'd2
    } t_step;

    // Indexed by {previous A, previous B, current A, current B}
    localparam t_step STEP_LUT [16] = '{
        ST_HOLD, ST_REV,  ST_FWD,  ST_HOLD,
        ST_FWD,  ST_HOLD, ST_HOLD, ST_REV,
        ST_REV,  ST_HOLD, ST_HOLD, ST_FWD,
        ST_HOLD, ST_FWD,  ST_REV,  ST_HOLD
    };

    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic load_fast;  // load result straight from the decode path
        logic do_abs;     // take magnitude of the count delta
        logic do_mlo;     // low partial product, divisor product
        logic do_mhi;     // high partial product, clear divider
        logic do_div;     // one restoring division step
        logic load_slow;  // load saturated speed result
    } t_dp_cmd;

    typedef struct packed {
        logic speed_go;   // offered item samples speed with nonzero divisor
        logic div_last;   // final division step this cycle
    } t_dp_sts;

endpackage

### design/qecs_ctrl.sv
// ----------------------------------------------------------------------------
// qecs_ctrl: item sequencer
// Accepts items, runs the multiply/divide sequence for speed samples and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module qecs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_m_tready,
    input  qecs_pkg::t_dp_sts   i_sts,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    output qecs_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ABS  = 6'b000010,
        S_MLO  = 6'b000100,
        S_MHI  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.accept     = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.speed_go) begin
                        n_state = S_ABS;
                    end else begin
                        o_cmd.load_fast = 1'b1;
                    end
                end
            end
            S_ABS: begin
                o_cmd.do_abs = 1'b1;
                n_state      = S_MLO;
            end
            S_MLO: begin
                o_cmd.do_mlo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.do_mhi = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.do_div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.load_slow = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_m_tready) || o_cmd.load_fast || o_cmd.load_slow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input ready while a speed sample is in progress");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_fast || o_cmd.load_slow) |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_speed_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.speed_go) |=> (r_state == S_ABS) && !r_out_valid || (r_state == S_ABS))
        else $error("speed sample did not start the divide sequence");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divider finish not followed by result stage");
`endif

endmodule

### design/qecs_dp.sv
// ----------------------------------------------------------------------------
// qecs_dp: decode, count and speed datapath
// Transition decode, position/sample state, two-step multiply and a
// one-bit-per-cycle restoring divider, plus the output register.
// ----------------------------------------------------------------------------
module qecs_dp #(
    parameter int unsigned COUNT_WIDTH = qecs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  qecs_pkg::t_dp_cmd                   i_cmd,
    output qecs_pkg::t_dp_sts                   o_sts,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [qecs_pkg::CPR_W-1:0]          i_cfg_wdata,
    input  logic [1:0]                          i_opcode,
    input  logic                                i_pin_a,
    input  logic                                i_pin_b,
    input  logic                                i_ms_tick,
    input  logic signed [qecs_pkg::LOAD_W-1:0]  i_load_value,
    output logic signed [qecs_pkg::OUT_W-1:0]   o_position_count,
    output logic signed [qecs_pkg::OUT_W-1:0]   o_old_count,
    output logic signed [qecs_pkg::OUT_W-1:0]   o_rpm_q8,
    output logic                                o_rpm_valid
);

    localparam int unsigned CW    = COUNT_WIDTH;
    localparam int unsigned PW    = COUNT_WIDTH + qecs_pkg::RPM_SCALE_W;
    localparam int unsigned DW    = qecs_pkg::CPR_W + qecs_pkg::MS_W;
    localparam int unsigned CNT_W = $clog2(PW);
    localparam int unsigned PP_W  = 32 + qecs_pkg::RPM_SCALE_W;
    localparam int unsigned OW    = qecs_pkg::OUT_W;

    // configuration
    logic                        r_dir_neg;
    logic [qecs_pkg::CPR_W-1:0]  r_cpr;

    // decoder and sample state
    logic [CW-1:0]               r_pos, n_pos;
    logic [1:0]                  r_prev;
    logic                        r_primed;
    logic [qecs_pkg::MS_W-1:0]   r_millis;
    logic [CW-1:0]               r_sample_pos;
    logic [qecs_pkg::MS_W-1:0]   r_sample_time;

    // speed pipeline
    logic [CW-1:0]               r_delta;
    logic                        r_neg;
    logic [qecs_pkg::MS_W-1:0]   r_elapsed;
    logic [CW-1:0]               r_mag;
    logic [DW-1:0]               r_div;
    logic [PW-1:0]               r_prod;
    logic [DW-1:0]               r_rem;
    logic [OW:0]                 r_q;
    logic                        r_big;
    logic [CNT_W-1:0]            r_cnt;

    logic [1:0]                  w_cur;
    qecs_pkg::t_step             w_step;
    logic                        w_up, w_dn;
    logic [CW-1:0]               w_pos_dec;
    logic [CW-1:0]               w_delta;
    logic [CW-1:0]               w_load_cw;
    logic [qecs_pkg::MS_W-1:0]   w_millis_nx;
    logic [qecs_pkg::MS_W-1:0]   w_elapsed;
    logic                        w_speed_go;
    logic [63:0]                 w_mag64;
    logic [PP_W-1:0]             w_pp_lo, w_pp_hi;
    logic [DW:0]                 w_rem_sh, w_rem_sub;
    logic                        w_ge;
    logic [OW-1:0]               w_rpm;
    logic                        w_ovf;

    // ---------------- decode ----------------
    assign w_cur       = {i_pin_a, i_pin_b};
    assign w_step      = qecs_pkg::STEP_LUT[{r_prev, w_cur}];
    assign w_up        = r_primed && ((w_step == qecs_pkg::ST_FWD && !r_dir_neg) ||
                                      (w_step == qecs_pkg::ST_REV &&  r_dir_neg));
    assign w_dn        = r_primed && ((w_step == qecs_pkg::ST_REV && !r_dir_neg) ||
                                      (w_step == qecs_pkg::ST_FWD &&  r_dir_neg));
    assign w_pos_dec   = w_up ? r_pos + CW'(1) : (w_dn ? r_pos - CW'(1) : r_pos);
    assign w_delta     = w_pos_dec - r_sample_pos;
    assign w_load_cw   = CW'(i_load_value);
    assign w_millis_nx = r_millis + qecs_pkg::MS_W'(i_ms_tick);
    assign w_elapsed   = w_millis_nx - r_sample_time;
    assign w_speed_go  = (i_opcode == qecs_pkg::OP_SPEED) && (w_elapsed != '0) && (r_cpr != '0);

    always_comb begin
        case (i_opcode)
            qecs_pkg::OP_RESET: n_pos = '0;
            qecs_pkg::OP_LOAD:  n_pos = w_load_cw;
            default:            n_pos = w_pos_dec;
        endcase
    end

    // ---------------- multiply ----------------
    assign w_mag64 = 64'(r_mag);
    assign w_pp_lo = PP_W'(w_mag64[31:0])  * PP_W'(qecs_pkg::RPM_SCALE_Q8);
    assign w_pp_hi = PP_W'(w_mag64[63:32]) * PP_W'(qecs_pkg::RPM_SCALE_Q8);

    // ---------------- divide step ----------------
    assign w_rem_sh  = {r_rem, r_prod[PW-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_div};
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    assign o_sts.speed_go = w_speed_go;
    assign o_sts.div_last = (r_cnt == CNT_W'(PW - 1));

    // ---------------- truncate and saturate ----------------
    assign w_ovf = r_big || r_q[OW];
    always_comb begin
        if (r_neg) begin
            w_rpm = (w_ovf || r_q[OW-1:0] > {1'b1, {(OW-1){1'b0}}}) ?
                    {1'b1, {(OW-1){1'b0}}} : OW'(-r_q[OW-1:0]);
        end else begin
            w_rpm = (w_ovf || r_q[OW-1]) ? {1'b0, {(OW-1){1'b1}}} : r_q[OW-1:0];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_neg     <= 1'b0;
            r_cpr         <= '0;
            r_pos         <= '0;
            r_prev        <= '0;
            r_primed      <= 1'b0;
            r_millis      <= '0;
            r_sample_pos  <= '0;
            r_sample_time <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    qecs_pkg::CFG_DIR_NEG: r_dir_neg <= i_cfg_wdata[0];
                    qecs_pkg::CFG_CPR:     r_cpr     <= i_cfg_wdata;
                    default:               r_cpr     <= r_cpr;
                endcase
            end
            if (i_cmd.accept) begin
                r_millis <= w_millis_nx;
                r_primed <= 1'b1;
                r_prev   <= w_cur;
                r_pos    <= n_pos;
                case (i_opcode)
                    qecs_pkg::OP_RESET: begin
                        r_sample_pos  <= '0;
                        r_sample_time <= w_millis_nx;
                    end
                    qecs_pkg::OP_LOAD: begin
                        r_sample_pos  <= w_load_cw;
                        r_sample_time <= w_millis_nx;
                    end
                    qecs_pkg::OP_SPEED: begin
                        if (w_speed_go) begin
                            r_sample_pos  <= w_pos_dec;
                            r_sample_time <= w_millis_nx;
                        end
                    end
                    default: begin
                        r_sample_pos <= r_sample_pos;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_speed_go) begin
            r_delta   <= w_delta;
            r_neg     <= w_delta[CW-1];
            r_elapsed <= w_elapsed;
        end
        if (i_cmd.do_abs) begin
            r_mag <= r_neg ? CW'(-r_delta) : r_delta;
        end
        if (i_cmd.do_mlo) begin
            r_prod <= PW'(w_pp_lo);
            r_div  <= DW'(r_elapsed) * DW'(r_cpr);
        end
        if (i_cmd.do_mhi) begin
            r_prod <= r_prod + PW'({w_pp_hi, 32'd0});
            r_rem  <= '0;
            r_q    <= '0;
            r_big  <= 1'b0;
            r_cnt  <= '0;
        end
        if (i_cmd.do_div) begin
            r_rem  <= w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
            r_q    <= {r_q[OW-1:0], w_ge};
            r_big  <= r_big | r_q[OW];
            r_prod <= {r_prod[PW-2:0], 1'b0};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.load_fast) begin
            o_position_count <= OW'(signed'(n_pos));
            o_old_count      <= (i_opcode == qecs_pkg::OP_RESET) ?
                                OW'(signed'(w_pos_dec)) : '0;
            o_rpm_q8         <= '0;
            o_rpm_valid      <= 1'b0;
        end else if (i_cmd.load_slow) begin
            o_position_count <= OW'(signed'(r_pos));
            o_old_count      <= '0;
            o_rpm_q8         <= w_rpm;
            o_rpm_valid      <= 1'b1;
        end
    end

endmodule

### design/quadrature_encoder_counter_speed.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_counter_speed: 4x quadrature counter with speed sample
// Decodes A/B transitions into a wrapping count and answers sample-speed,
// read-and-reset and load requests with one result per item.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s stream | in  | tuser: opcode; tdata: pin_a, pin_b, ms_tick, load_value
//  m stream | out | tdata: position_count, old_count, rpm_q8; tuser: rpm_valid
//  cfg      | in  | 0 direction_negative, 1 counts_per_rev
//
//  Pin, read-and-reset, load and zero-divisor speed items: one per cycle.
//  A speed sample with nonzero elapsed time and counts_per_rev runs the
//  magnitude, multiply and one-bit-per-cycle restoring divider steps.
//  Input ready drops for that sample and while an untaken result blocks
//  the output register. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter_speed #(
    parameter int unsigned COUNT_WIDTH = qecs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [qecs_pkg::S_TDATA_W-1:0]     i_s_tdata,  // pin_a, pin_b, ms_tick,
                                                           // load_value[31:0], pad
    input  logic [1:0]                         i_s_tuser,  // opcode
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [qecs_pkg::M_TDATA_W-1:0]     o_m_tdata,  // position_count, old_count,
                                                           // rpm_q8
    output logic                               o_m_tuser,  // rpm_valid
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_index,
    input  logic [qecs_pkg::CPR_W-1:0]         i_cfg_wdata
);

    qecs_pkg::t_dp_cmd                  w_cmd;
    qecs_pkg::t_dp_sts                  w_sts;
    logic signed [qecs_pkg::OUT_W-1:0]  w_position_count;
    logic signed [qecs_pkg::OUT_W-1:0]  w_old_count;
    logic signed [qecs_pkg::OUT_W-1:0]  w_rpm_q8;

    qecs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    qecs_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_s_tuser),
        .i_pin_a          (i_s_tdata[0]),
        .i_pin_b          (i_s_tdata[1]),
        .i_ms_tick        (i_s_tdata[2]),
        .i_load_value     (i_s_tdata[34:3]),
        .o_position_count (w_position_count),
        .o_old_count      (w_old_count),
        .o_rpm_q8         (w_rpm_q8),
        .o_rpm_valid      (o_m_tuser)
    );

    assign o_m_tdata = {w_rpm_q8, w_old_count, w_position_count};

endmodule
